>>> rtl/core/otsu_threshold_binarizer_assert.svh
// Assertion macros for the Otsu threshold binariser RTL.
// Needs clk and rst_n in the scope of each use.
`ifndef OTSU_THRESHOLD_BINARIZER_ASSERT_SVH
`define OTSU_THRESHOLD_BINARIZER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define OTB_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("otb: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent
`define OTB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("otb: next-cycle check failed");

`endif

>>> rtl/core/otb_pkg.sv
// Shared types and constants of the Otsu threshold binariser.
// No dependencies.
package otb_pkg;

  localparam int LVL_W    = 8;
  localparam int LEVELS   = 256;
  localparam logic [LVL_W-1:0] LVL_MAX = 8'd255;

  // Big-number multiplier geometry
  localparam int LIMB_W = 32;
  localparam int X_W    = 128;
  localparam int Y_W    = 64;
  localparam int P_W    = 192;

  localparam logic CMD_HIST = 1'b0;
  localparam logic CMD_BIN  = 1'b1;
  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_PIXEL  = 1'b1;

  typedef struct packed {
    logic             cmd;
    logic [LVL_W-1:0] pixel;
    logic             last;
  } otb_in_t;

  typedef struct packed {
    logic             kind;
    logic             bit_res;
    logic [LVL_W-1:0] threshold;
    logic             frame_end;
  } otb_out_t;

  typedef struct packed {
    logic           start;
    logic [X_W-1:0] x;
    logic [Y_W-1:0] y;
  } otb_mul_req_t;

endpackage

>>> rtl/core/otb_ram.sv
// Generic simple dual-port RAM with registered read (read-before-write).
// No dependencies.
module otb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/otb_mul.sv
// Limb-serial 128 x 64 bit multiplier, one 32 x 32 partial product a cycle.
// Depends on otb_pkg.
module otb_mul import otb_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  otb_mul_req_t   req,
  output logic           done,
  output logic [P_W-1:0] prod
);

  logic [X_W-1:0]    x_r;
  logic [Y_W-1:0]    y_r;
  logic [2:0]        k_r;
  logic              busy_r;
  logic              pp_v_r;
  logic              pp_last_r;
  logic [2*LIMB_W-1:0] pp_r;
  logic [2:0]        sh_r;
  logic [P_W-1:0]    acc_r;
  logic              done_r;
  logic [LIMB_W-1:0] xl;
  logic [LIMB_W-1:0] yl;

  // Pick the limbs of this partial product
  assign xl = x_r[LIMB_W*k_r[1:0] +: LIMB_W];
  assign yl = y_r[LIMB_W*k_r[2] +: LIMB_W];

  // Sequence control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      pp_v_r    <= 1'b0;
      pp_last_r <= 1'b0;
      done_r    <= 1'b0;
      k_r       <= '0;
    end else begin
      done_r <= pp_v_r && pp_last_r;
      if (req.start) begin
        busy_r <= 1'b1;
        k_r    <= '0;
        pp_v_r <= 1'b0;
      end else if (busy_r) begin
        pp_v_r    <= 1'b1;
        pp_last_r <= (k_r == 3'd7);
        k_r       <= k_r + 3'd1;
        if (k_r == 3'd7) begin
          busy_r <= 1'b0;
        end
      end else begin
        pp_v_r <= 1'b0;
      end
    end
  end

  // Operands, partial product and accumulator
  always_ff @(posedge clk) begin
    if (req.start) begin
      x_r   <= req.x;
      y_r   <= req.y;
      acc_r <= '0;
    end else if (pp_v_r) begin
      acc_r <= acc_r + ({{(P_W-2*LIMB_W){1'b0}}, pp_r} << (LIMB_W * sh_r));
    end
    if (busy_r) begin
      pp_r <= xl * yl;
      sh_r <= {1'b0, k_r[1:0]} + {2'b0, k_r[2]};
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

>>> rtl/core/otsu_threshold_binarizer.sv
// Top level of the Otsu threshold binariser.
// Depends on otb_pkg, otb_ram, otb_mul and otsu_threshold_binarizer_assert.svh.
//
// Use: pixels arrive on in_valid/in_stall/in_data (cmd, pixel, last).
// A histogram pixel (cmd 0) adds to its bin; with last set the block then
// scans all 256 levels, stores the level of greatest between-class variance,
// clears the histogram and returns one report (kind 0, frame_end 1).
// A binarise pixel (cmd 1) returns one registered result, bit_res set
// when the pixel is above the stored threshold.
// Throughput: one pixel per cycle in either pass while in_stall is low;
// results leave through a single output register, so in S_RUN the input
// stalls only while that register is full and out_stall is high.
// Histogram bins live in one 256-entry RAM updated by read-modify-write with
// forwarding of the previous write. The scan reads and clears one bin per
// level; a level with an empty class skips the multiplier, any other one
// runs four or six products through the shared 32 x 32 limb multiplier.
// During a full scan in_stall is high.
// After reset the block clears all 256 bins with in_stall high.
// Pixels beyond MAX_PIXELS in a histogram pass are not counted.
`include "otsu_threshold_binarizer_assert.svh"

module otsu_threshold_binarizer import otb_pkg::*; #(
  parameter int MAX_PIXELS = 1048576
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  otb_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output otb_out_t out_data
);

  localparam int CNT_W = $clog2(MAX_PIXELS + 1);
  localparam int E_W   = CNT_W + LVL_W;

  typedef enum logic [13:0] {
    S_CLEAR  = 14'b00000000000001,
    S_RUN    = 14'b00000000000010,
    S_WAIT   = 14'b00000000000100,
    S_RD     = 14'b00000000001000,
    S_ACC    = 14'b00000000010000,
    S_CHK    = 14'b00000000100000,
    S_MA     = 14'b00000001000000,
    S_MB     = 14'b00000010000000,
    S_MQ     = 14'b00000100000000,
    S_MSQ    = 14'b00001000000000,
    S_ML     = 14'b00010000000000,
    S_MR     = 14'b00100000000000,
    S_NEXT   = 14'b01000000000000,
    S_REPORT = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [LVL_W-1:0] lvl_r, lvl_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic [E_W-1:0]   e_r, e_nxt;
  logic [CNT_W-1:0] p_r, p_nxt;
  logic [E_W-1:0]   e1_r, e1_nxt;
  logic             found_r, found_nxt;
  logic [LVL_W-1:0] best_r, best_nxt;
  logic [X_W-1:0]   best_sq_r, best_sq_nxt;
  logic [Y_W-1:0]   best_q_r, best_q_nxt;
  logic [LVL_W-1:0] chosen_r, chosen_nxt;
  logic [Y_W-1:0]   a_r, a_nxt;
  logic [Y_W-1:0]   d_r, d_nxt;
  logic [Y_W-1:0]   q_r, q_nxt;
  logic [X_W-1:0]   sq_r, sq_nxt;
  logic [P_W-1:0]   lhs_r, lhs_nxt;

  logic             s1_valid_r;
  logic [LVL_W-1:0] s1_addr_r;
  logic             lw_valid_r;
  logic [LVL_W-1:0] lw_addr_r;
  logic [CNT_W-1:0] lw_data_r;

  logic             out_valid_r, out_valid_nxt;
  otb_out_t         out_data_r, out_data_nxt;

  logic             ram_we;
  logic [LVL_W-1:0] ram_waddr;
  logic [CNT_W-1:0] ram_wdata;
  logic [LVL_W-1:0] ram_raddr;
  logic [CNT_W-1:0] ram_rdata;
  logic [CNT_W-1:0] inc_val;

  otb_mul_req_t     mreq;
  logic             mdone;
  logic [P_W-1:0]   mprod;

  logic slot_free;
  logic in_acc;
  logic count_ok;
  logic hist_acc;
  logic [Y_W-1:0] b_val;

  otb_ram #(.WIDTH(CNT_W), .DEPTH(LEVELS)) u_bins (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  otb_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .done  (mdone),
    .prod  (mprod)
  );

  // Input and output handshake
  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_RUN) || !slot_free;
  assign in_acc    = in_valid && !in_stall;
  assign count_ok  = n_r < CNT_W'(MAX_PIXELS);
  assign hist_acc  = in_acc && (in_data.cmd == CMD_HIST) && count_ok;

  // Increment the bin, forwarding last cycle's write to the same bin
  assign inc_val = ((lw_valid_r && (lw_addr_r == s1_addr_r)) ? lw_data_r : ram_rdata)
                   + CNT_W'(1);

  // Histogram RAM ports
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = lvl_r;
    ram_wdata = '0;
    if (state_r == S_CLEAR) begin
      ram_we = 1'b1;
    end else if (s1_valid_r) begin
      ram_we    = 1'b1;
      ram_waddr = s1_addr_r;
      ram_wdata = inc_val;
    end else if (state_r == S_RD) begin
      ram_we = 1'b1;
    end
  end

  assign ram_raddr = (state_r == S_RUN) ? in_data.pixel : lvl_r;
  assign b_val     = mprod[Y_W-1:0];

  // Main sequencer
  always_comb begin
    state_nxt     = state_r;
    lvl_nxt       = lvl_r;
    n_nxt         = n_r;
    e_nxt         = e_r;
    p_nxt         = p_r;
    e1_nxt        = e1_r;
    found_nxt     = found_r;
    best_nxt      = best_r;
    best_sq_nxt   = best_sq_r;
    best_q_nxt    = best_q_r;
    chosen_nxt    = chosen_r;
    a_nxt         = a_r;
    d_nxt         = d_r;
    q_nxt         = q_r;
    sq_nxt        = sq_r;
    lhs_nxt       = lhs_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    mreq          = '0;

    case (state_r)
      S_CLEAR: begin
        lvl_nxt = lvl_r + LVL_W'(1);
        if (lvl_r == LVL_MAX) begin
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        if (hist_acc) begin
          n_nxt = n_r + CNT_W'(1);
          e_nxt = e_r + E_W'(in_data.pixel);
        end
        if (in_acc && (in_data.cmd == CMD_BIN)) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.kind      = KIND_PIXEL;
          out_data_nxt.bit_res   = in_data.pixel > chosen_r;
          out_data_nxt.threshold = chosen_r;
          out_data_nxt.frame_end = in_data.last;
        end
        if (in_acc && (in_data.cmd == CMD_HIST) && in_data.last) begin
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        // let the final bin write land, then start the scan
        lvl_nxt   = '0;
        p_nxt     = '0;
        e1_nxt    = '0;
        found_nxt = 1'b0;
        best_nxt  = '0;
        state_nxt = S_RD;
      end
      S_RD: begin
        state_nxt = S_ACC;
      end
      S_ACC: begin
        p_nxt     = p_r + ram_rdata;
        e1_nxt    = e1_r + E_W'(E_W'(lvl_r) * E_W'(ram_rdata));
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if ((p_r == '0) || (p_r >= n_r)) begin
          state_nxt = S_NEXT;
        end else begin
          mreq.start = 1'b1;
          mreq.x     = X_W'(e1_r);
          mreq.y     = Y_W'(n_r);
          state_nxt  = S_MA;
        end
      end
      S_MA: begin
        if (mdone) begin
          a_nxt      = mprod[Y_W-1:0];
          mreq.start = 1'b1;
          mreq.x     = X_W'(e_r);
          mreq.y     = Y_W'(p_r);
          state_nxt  = S_MB;
        end
      end
      S_MB: begin
        if (mdone) begin
          d_nxt      = (a_r >= b_val) ? (a_r - b_val) : (b_val - a_r);
          mreq.start = 1'b1;
          mreq.x     = X_W'(p_r);
          mreq.y     = Y_W'(n_r - p_r);
          state_nxt  = S_MQ;
        end
      end
      S_MQ: begin
        if (mdone) begin
          q_nxt      = mprod[Y_W-1:0];
          mreq.start = 1'b1;
          mreq.x     = X_W'(d_r);
          mreq.y     = d_r;
          state_nxt  = S_MSQ;
        end
      end
      S_MSQ: begin
        if (mdone) begin
          sq_nxt = mprod[X_W-1:0];
          if (!found_r) begin
            found_nxt   = 1'b1;
            best_nxt    = lvl_r;
            best_sq_nxt = mprod[X_W-1:0];
            best_q_nxt  = q_r;
            state_nxt   = S_NEXT;
          end else begin
            mreq.start = 1'b1;
            mreq.x     = mprod[X_W-1:0];
            mreq.y     = best_q_r;
            state_nxt  = S_ML;
          end
        end
      end
      S_ML: begin
        if (mdone) begin
          lhs_nxt    = mprod;
          mreq.start = 1'b1;
          mreq.x     = best_sq_r;
          mreq.y     = q_r;
          state_nxt  = S_MR;
        end
      end
      S_MR: begin
        if (mdone) begin
          // strictly greater keeps the first level among equals
          if (lhs_r > mprod) begin
            best_nxt    = lvl_r;
            best_sq_nxt = sq_r;
            best_q_nxt  = q_r;
          end
          state_nxt = S_NEXT;
        end
      end
      S_NEXT: begin
        lvl_nxt = lvl_r + LVL_W'(1);
        if (lvl_r == LVL_MAX) begin
          state_nxt = S_REPORT;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_REPORT: begin
        if (slot_free) begin
          chosen_nxt             = best_r;
          n_nxt                  = '0;
          e_nxt                  = '0;
          out_valid_nxt          = 1'b1;
          out_data_nxt.kind      = KIND_REPORT;
          out_data_nxt.bit_res   = 1'b0;
          out_data_nxt.threshold = best_r;
          out_data_nxt.frame_end = 1'b1;
          state_nxt              = S_RUN;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      lvl_r       <= '0;
      n_r         <= '0;
      e_r         <= '0;
      chosen_r    <= '0;
      found_r     <= 1'b0;
      best_r      <= '0;
      s1_valid_r  <= 1'b0;
      lw_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lvl_r       <= lvl_nxt;
      n_r         <= n_nxt;
      e_r         <= e_nxt;
      chosen_r    <= chosen_nxt;
      found_r     <= found_nxt;
      best_r      <= best_nxt;
      s1_valid_r  <= hist_acc;
      lw_valid_r  <= s1_valid_r;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    p_r        <= p_nxt;
    e1_r       <= e1_nxt;
    best_sq_r  <= best_sq_nxt;
    best_q_r   <= best_q_nxt;
    a_r        <= a_nxt;
    d_r        <= d_nxt;
    q_r        <= q_nxt;
    sq_r       <= sq_nxt;
    lhs_r      <= lhs_nxt;
    out_data_r <= out_data_nxt;
    s1_addr_r  <= in_data.pixel;
    lw_addr_r  <= s1_addr_r;
    lw_data_r  <= inc_val;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks
  `OTB_ASSERT_SAME(a_mul_done_state, mdone, (state_r == S_MA || state_r == S_MB || state_r == S_MQ || state_r == S_MSQ || state_r == S_ML || state_r == S_MR))
  `OTB_ASSERT_SAME(a_bin_write_state, s1_valid_r, (state_r == S_RUN || state_r == S_WAIT))
  `OTB_ASSERT_SAME(a_count_cap, 1'b1, (n_r <= CNT_W'(MAX_PIXELS)))
  `OTB_ASSERT_NEXT(a_last_to_scan, (in_acc && in_data.cmd == CMD_HIST && in_data.last), (state_r == S_WAIT))
  `OTB_ASSERT_NEXT(a_report_out, (state_r == S_REPORT && slot_free), (out_valid_r && out_data_r.kind == KIND_REPORT && out_data_r.frame_end))

endmodule

>>> tb/sv/tb_top.sv
// Testbench for otsu_threshold_binarizer: predicts thresholds and binary pixels
// from its own histogram model and checks every result transfer in order.
// Depends on otb_pkg and the otsu_threshold_binarizer RTL.
`timescale 1ns / 1ps

module tb_top import otb_pkg::*; ();

  localparam int MAX_PIX = 1048576;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  otb_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  otb_out_t out_data;

  otsu_threshold_binarizer #(.MAX_PIXELS(MAX_PIX)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // Predictor state
  longint unsigned hist_bins [LEVELS];
  longint unsigned hist_count;
  longint unsigned hist_level_sum;
  logic [LVL_W-1:0] stored_level;

  otb_in_t  pixel_queue[$];
  otb_out_t expected_results[$];
  int       mismatch_count;
  int       send_idle_pct;
  int       recv_stall_pct;

  initial begin
    clk = 1'b0;
  end
  always #10 clk = ~clk;

  task automatic report_mismatch(input string what, input otb_out_t got, input otb_out_t want);
    $display("MISMATCH %s: got kind=%0d bit=%0d thr=%0d fe=%0d want kind=%0d bit=%0d thr=%0d fe=%0d",
             what, got.kind, got.bit_res, got.threshold, got.frame_end,
             want.kind, want.bit_res, want.threshold, want.frame_end);
    mismatch_count++;
  endtask

  // Exact comparison: dn^2*qb > db^2*qn; all values below 2^64, products below 2^192
  function automatic bit variance_greater(longint unsigned dn, longint unsigned qn,
                                          longint unsigned db, longint unsigned qb);
    logic [191:0] lhs;
    logic [191:0] rhs;
    lhs = {128'd0, dn} * {128'd0, dn} * {128'd0, qb};
    rhs = {128'd0, db} * {128'd0, db} * {128'd0, qn};
    return lhs > rhs;
  endfunction

  function automatic logic [LVL_W-1:0] otsu_scan();
    longint unsigned p, e1, a, b, d, q, best_d, best_q;
    bit found;
    logic [LVL_W-1:0] best;
    p = 0; e1 = 0; best_d = 0; best_q = 0; found = 0; best = '0;
    for (int i = 0; i < LEVELS; i++) begin
      p += hist_bins[i];
      e1 += longint'(i) * hist_bins[i];
      if (p == 0 || p >= hist_count) continue;
      a = e1 * hist_count;
      b = p * hist_level_sum;
      d = (a >= b) ? a - b : b - a;
      q = p * (hist_count - p);
      if (!found || variance_greater(d, q, best_d, best_q)) begin
        found = 1; best_d = d; best_q = q; best = i[LVL_W-1:0];
      end
    end
    return best;
  endfunction

  // Work out the result of one accepted pixel, if any
  task automatic predict_pixel(input otb_in_t px);
    otb_out_t r;
    if (px.cmd == CMD_BIN) begin
      r.kind = KIND_PIXEL;
      r.bit_res = (px.pixel > stored_level);
      r.threshold = stored_level;
      r.frame_end = px.last;
      expected_results.push_back(r);
    end else begin
      if (hist_count < MAX_PIX) begin
        hist_bins[px.pixel]++;
        hist_count++;
        hist_level_sum += px.pixel;
      end
      if (px.last) begin
        stored_level = otsu_scan();
        foreach (hist_bins[i]) hist_bins[i] = 0;
        hist_count = 0;
        hist_level_sum = 0;
        r.kind = KIND_REPORT;
        r.bit_res = 1'b0;
        r.threshold = stored_level;
        r.frame_end = 1'b1;
        expected_results.push_back(r);
      end
    end
  endtask

  // Driver: hold a payload until transferred, then advance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else begin
      if (in_valid && !in_stall) predict_pixel(in_data);
      if (!in_valid || !in_stall) begin
        if (pixel_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= pixel_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result transfer, randomise stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected", out_data, '0);
        end else if (out_data !== expected_results[0]) begin
          report_mismatch("field", out_data, expected_results.pop_front());
        end else begin
          void'(expected_results.pop_front());
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic add_pixel(input logic cmd, input logic [7:0] val, input logic last);
    otb_in_t px;
    px.cmd = cmd; px.pixel = val; px.last = last;
    pixel_queue.push_back(px);
  endtask

  task automatic wait_drained();
    while (pixel_queue.size() > 0 || in_valid) @(posedge clk);
    while (expected_results.size() > 0) @(posedge clk);
  endtask

  // One histogram frame of random content followed by a binarise pass
  task automatic add_frame(input int hist_len, input int bin_len);
    int lo, hi;
    lo = $urandom_range(255);
    hi = $urandom_range(255);
    if (lo > hi) begin int t; t = lo; lo = hi; hi = t; end
    for (int i = 0; i < hist_len; i++) begin
      add_pixel(CMD_HIST, ($urandom_range(3) == 0) ? 8'($urandom_range(255))
                          : 8'($urandom_range(hi, lo)), i == hist_len - 1);
    end
    for (int i = 0; i < bin_len; i++)
      add_pixel(CMD_BIN, 8'($urandom_range(255)), i == bin_len - 1);
  endtask

  initial begin
    int pct_sets [4][2];
    pct_sets = '{'{0, 0}, '{71, 0}, '{0, 71}, '{25, 25}};
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    mismatch_count = 0;
    hist_count = 0;
    hist_level_sum = 0;
    stored_level = '0;
    foreach (hist_bins[i]) hist_bins[i] = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty-ish frames, single level, two extremes, ties, mixed passes
    add_pixel(CMD_BIN, 8'd0, 1'b0);
    add_pixel(CMD_BIN, 8'd255, 1'b1);
    add_pixel(CMD_HIST, 8'd7, 1'b1);
    add_pixel(CMD_BIN, 8'd7, 1'b0);
    add_pixel(CMD_BIN, 8'd8, 1'b1);
    add_pixel(CMD_HIST, 8'd0, 1'b0);
    add_pixel(CMD_HIST, 8'd255, 1'b0);
    add_pixel(CMD_BIN, 8'd128, 1'b0);
    add_pixel(CMD_HIST, 8'd255, 1'b1);
    add_pixel(CMD_BIN, 8'd0, 1'b0);
    add_pixel(CMD_BIN, 8'd255, 1'b1);
    add_pixel(CMD_HIST, 8'd10, 1'b0);
    add_pixel(CMD_HIST, 8'd20, 1'b0);
    add_pixel(CMD_HIST, 8'd30, 1'b1);
    add_pixel(CMD_HIST, 8'hAA, 1'b0);
    add_pixel(CMD_HIST, 8'h55, 1'b0);
    add_pixel(CMD_HIST, 8'h55, 1'b0);
    add_pixel(CMD_HIST, 8'hAA, 1'b1);
    add_pixel(CMD_BIN, 8'h55, 1'b0);
    add_pixel(CMD_BIN, 8'hAA, 1'b1);
    wait_drained();

    // Random frames over every idling mix
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = pct_sets[ph][0];
      recv_stall_pct = pct_sets[ph][1];
      for (int f = 0; f < 18; f++)
        add_frame($urandom_range(12, 1), $urandom_range(24, 1));
      // stray binarise noise
      for (int i = 0; i < 10; i++)
        add_pixel(CMD_BIN, 8'($urandom_range(255)), 1'($urandom_range(1)));
      if (ph == 1) wait_drained();
    end
    wait_drained();
    repeat (200) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("otsu_threshold_binarizer verification clean");
    end else begin
      $display("otsu_threshold_binarizer verification failed");
    end
    $finish;
  end

  // Generous limit for the long scans under heavy stalling
  initial begin
    #200ms;
    $display("otsu_threshold_binarizer verification failed");
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/otb_pkg.sv
rtl/core/otb_ram.sv
rtl/core/otb_mul.sv
rtl/core/otsu_threshold_binarizer.sv
tb/sv/tb_top.sv
